// ===== rtl/core/tch_pkg.sv =====
// tilt compensated heading package: cordic angle table and fixed formats
// no dependencies
`timescale 1ns / 1ps
package tch_pkg;
  localparam int TableLen = 24;
  localparam int AngW = 28;                        // q16 degrees, covers +-2048 deg
  localparam int TrigW = 32;                       // q30 sin / cos with headroom
  localparam int VecW = 52;                        // counts times q30, plus growth
  localparam logic signed [AngW-1:0] Deg90  = 28'sd5898240;
  localparam logic signed [AngW-1:0] Deg180 = 28'sd11796480;
  localparam logic signed [AngW-1:0] Deg360 = 28'sd23592960;
  localparam logic signed [TrigW-1:0] InvGainQ30 = 32'sd652032874;

  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    logic signed [AngW-1:0] t;
    begin
      case (i)
        0: t = 28'sd2949120;  1: t = 28'sd1740967;  2: t = 28'sd919879;
        3: t = 28'sd466945;   4: t = 28'sd234379;   5: t = 28'sd117304;
        6: t = 28'sd58666;    7: t = 28'sd29335;    8: t = 28'sd14668;
        9: t = 28'sd7334;     10: t = 28'sd3667;    11: t = 28'sd1833;
        12: t = 28'sd917;     13: t = 28'sd458;     14: t = 28'sd229;
        15: t = 28'sd115;     16: t = 28'sd57;      17: t = 28'sd29;
        18: t = 28'sd14;      19: t = 28'sd7;       20: t = 28'sd4;
        21: t = 28'sd2;       22: t = 28'sd1;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  typedef struct packed {
    logic signed [TrigW-1:0] x;
    logic signed [TrigW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic                    flip;
  } rot_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } vec_t;
endpackage

// ===== rtl/core/tch_rot_cell.sv =====
// one rotation-mode cordic cell: sin/cos of pitch and roll, one micro-rotation
// depends on tch_pkg
`timescale 1ns / 1ps
module tch_rot_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  tch_pkg::rot_t  p_in,
  input  tch_pkg::rot_t  r_in,
  output tch_pkg::rot_t  p_out,
  output tch_pkg::rot_t  r_out
);
  import tch_pkg::*;

  function automatic rot_t step(input rot_t a);
    rot_t b;
    begin
      b = a;
      if (a.z >= 0) begin
        b.x = a.x - (a.y >>> STEP);
        b.y = a.y + (a.x >>> STEP);
        b.z = a.z - atan_q16(STEP);
      end else begin
        b.x = a.x + (a.y >>> STEP);
        b.y = a.y - (a.x >>> STEP);
        b.z = a.z + atan_q16(STEP);
      end
      return b;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= step(p_in);
      r_out <= step(r_in);
    end
  end
endmodule

// ===== rtl/core/tch_vec_cell.sv =====
// one vectoring-mode cordic cell for atan2
// depends on tch_pkg
`timescale 1ns / 1ps
module tch_vec_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  tch_pkg::vec_t v_in,
  output tch_pkg::vec_t v_out
);
  import tch_pkg::*;

  vec_t n;

  always_comb begin
    n = v_in;
    if (v_in.y > 0) begin
      n.x = v_in.x + (v_in.y >>> STEP);
      n.y = v_in.y - (v_in.x >>> STEP);
      n.z = v_in.z + atan_q16(STEP);
    end else begin
      n.x = v_in.x - (v_in.y >>> STEP);
      n.y = v_in.y + (v_in.x >>> STEP);
      n.z = v_in.z - atan_q16(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) v_out <= n;
  end
endmodule

// ===== rtl/core/tilt_compensated_heading.sv =====
// tilt compensated compass heading, top level
// one item per cycle while the output is not stalled; the input is stalled along with it
// the pipeline is a row of cordic cells, sin/cos row then atan2 row, one step per cell
// the whole pipe advances when the output register is free or empty
// reset clears the valid bits only; payload registers are not reset
// depends on tch_pkg, tch_rot_cell, tch_vec_cell
`timescale 1ns / 1ps
module tilt_compensated_heading #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  input  logic signed [15:0] pitch_deg,
  input  logic signed [15:0] roll_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] heading_deg
);
  import tch_pkg::*;

  localparam int NSteps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam int QShift = 16 - ANGLE_FRAC_BITS;
  // stages: wrap, rot cells, negate, products, combine, sign fold, vec cells;
  // the round stage is the output register itself
  localparam int Lat = 2 * NSteps + 5;
  localparam int LimRaw = 180 * (1 << ANGLE_FRAC_BITS);
  localparam int LimI = (LimRaw > 32767) ? 32767 : LimRaw;
  localparam logic signed [AngW-1:0] Lim = AngW'(LimI);

  // one enable moves the whole row; the last stage feeds the output register
  logic adv;
  logic [Lat-1:0] vld;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], in_valid};
      out_valid <= vld[Lat-1];
    end
  end

  // magnetometer axes ride alongside the trig row
  logic signed [15:0] mx_d [NSteps+2];
  logic signed [15:0] my_d [NSteps+2];
  logic signed [15:0] mz_d [NSteps+2];

  // angle wrap into +-90 with a flip flag
  function automatic rot_t wrap(input logic signed [15:0] a);
    rot_t r;
    logic signed [AngW-1:0] q;
    begin
      q = AngW'(a) <<< QShift;
      // inputs reach at most +-256 deg at 7 frac bits, +-2048 at 4: a few turns
      for (int k = 0; k < 6; k++) begin
        if (q > Deg180) q = q - Deg360;
        else if (q < -Deg180) q = q + Deg360;
      end
      r.flip = 1'b0;
      if (q > Deg90) begin
        q = q - Deg180;
        r.flip = 1'b1;
      end else if (q < -Deg90) begin
        q = q + Deg180;
        r.flip = 1'b1;
      end
      r.x = InvGainQ30;
      r.y = '0;
      r.z = q;
      return r;
    end
  endfunction

  rot_t p_row [NSteps+1];
  rot_t r_row [NSteps+1];
  rot_t p_wrap, r_wrap;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wrap <= wrap(pitch_deg);
      r_wrap <= wrap(roll_deg);
      mx_d[0] <= mag_x;
      my_d[0] <= mag_y;
      mz_d[0] <= mag_z;
      for (int k = 1; k < NSteps + 2; k++) begin
        mx_d[k] <= mx_d[k-1];
        my_d[k] <= my_d[k-1];
        mz_d[k] <= mz_d[k-1];
      end
    end
  end

  assign p_row[0] = p_wrap;
  assign r_row[0] = r_wrap;

  // rotation cells; each cell register is one pipeline stage, held on stall
  for (genvar g = 0; g < NSteps; g++) begin : g_rot
    tch_rot_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(adv), .p_in(p_row[g]), .r_in(r_row[g]),
      .p_out(p_row[g+1]), .r_out(r_row[g+1])
    );
  end

  // apply flips
  logic signed [TrigW-1:0] sp, cp, sr, cr;
  always_ff @(posedge clk) begin
    if (adv) begin
      sp <= p_row[NSteps].flip ? -p_row[NSteps].y : p_row[NSteps].y;
      cp <= p_row[NSteps].flip ? -p_row[NSteps].x : p_row[NSteps].x;
      sr <= r_row[NSteps].flip ? -r_row[NSteps].y : r_row[NSteps].y;
      cr <= r_row[NSteps].flip ? -r_row[NSteps].x : r_row[NSteps].x;
    end
  end

  // products: trig by trig, counts by trig
  logic signed [63:0] spsr_f, spcr_f;
  logic signed [VecW-1:0] t_zsr, t_ycr, t_xcp;
  logic signed [15:0] my_p, mz_p;
  always_ff @(posedge clk) begin
    if (adv) begin
      spsr_f <= 64'(sp) * 64'(sr);
      spcr_f <= 64'(sp) * 64'(cr);
      t_zsr  <= VecW'(mz_d[NSteps+1]) * VecW'(sr);
      t_ycr  <= VecW'(my_d[NSteps+1]) * VecW'(cr);
      t_xcp  <= VecW'(mx_d[NSteps+1]) * VecW'(cp);
      my_p <= my_d[NSteps+1];
      mz_p <= mz_d[NSteps+1];
    end
  end

  // second products and sums
  logic signed [VecW-1:0] yh, xh;
  logic signed [TrigW-1:0] spsr, spcr;
  assign spsr = TrigW'(spsr_f >>> 30);
  assign spcr = TrigW'(spcr_f >>> 30);
  always_ff @(posedge clk) begin
    if (adv) begin
      yh <= t_zsr - t_ycr;
      xh <= t_xcp + VecW'(my_p) * VecW'(spsr) + VecW'(mz_p) * VecW'(spcr);
    end
  end

  // fold into the right half plane
  vec_t v_row [NSteps+1];
  vec_t v_fold;
  always_ff @(posedge clk) begin
    if (adv) begin
      v_fold.zero <= (xh == 0) && (yh == 0);
      if (xh < 0) begin
        v_fold.x <= -xh;
        v_fold.y <= -yh;
        v_fold.z <= (yh >= 0) ? Deg180 : -Deg180;
      end else begin
        v_fold.x <= xh;
        v_fold.y <= yh;
        v_fold.z <= '0;
      end
    end
  end

  assign v_row[0] = v_fold;

  for (genvar g = 0; g < NSteps; g++) begin : g_vec
    tch_vec_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(adv), .v_in(v_row[g]), .v_out(v_row[g+1])
    );
  end

  // round half up to the output format and saturate
  logic signed [AngW-1:0] hz;
  always_comb begin
    hz = (v_row[NSteps].z + AngW'(1 << (QShift - 1))) >>> QShift;
    if (v_row[NSteps].zero) hz = '0;
    if (hz > Lim) hz = Lim;
    if (hz < -Lim) hz = -Lim;
  end

  always_ff @(posedge clk) begin
    if (adv) heading_deg <= 16'(hz);
  end

  // the output register holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(heading_deg))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_deg <= 16'(LimI)) && (heading_deg >= -16'(LimI)))
    else $error("heading out of range");
endmodule

// ===== tb/tb_top.sv =====
// testbench for tilt_compensated_heading: random and directed sensor samples,
// headings checked against a cordic predictor kept in this file
// depends only on the rtl of tilt_compensated_heading
`timescale 1ns / 1ps
module tb_top;
  localparam int Steps     = 16;
  localparam int FracBits  = 7;
  localparam int Latency   = 2 * Steps + 9;
  localparam int NumRandom = 530;
  localparam int AngMax    = 180 * (1 << FracBits);     // 180 degrees in input format

  // q16 degree constants for the predictor
  localparam longint Q16Deg90  = 64'sd90 * 65536;
  localparam longint Q16Deg180 = 64'sd180 * 65536;
  localparam longint Q16Deg360 = 64'sd360 * 65536;
  localparam longint InvGain   = 64'sd652032874;        // 1/K in q30

  localparam longint AtanTab [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] mag_x = '0;
  logic signed [15:0] mag_y = '0;
  logic signed [15:0] mag_z = '0;
  logic signed [15:0] pitch_deg = '0;
  logic signed [15:0] roll_deg = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] heading_deg;

  sample_t            sample_q[$];          // samples waiting to be driven
  logic signed [15:0] heading_q[$];         // headings expected, oldest first
  int                 n_errors = 0;
  int                 n_sent = 0;
  int                 n_checked = 0;
  bit                 in_took = 0;          // set by the sampling edge after an input transfer
  bit                 out_took = 0;
  bit                 no_gaps = 0;          // stretches where the sender never idles
  bit                 no_stalls = 0;        // same for the receiver
  int                 send_gap = 0;
  int                 stall_left = 0;

  tilt_compensated_heading #(
    .CORDIC_STEPS   (Steps),
    .ANGLE_FRAC_BITS(FracBits)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mag_x      (mag_x),
    .mag_y      (mag_y),
    .mag_z      (mag_z),
    .pitch_deg  (pitch_deg),
    .roll_deg   (roll_deg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .heading_deg(heading_deg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rotation cordic: q16 degree angle in, q30 sine and cosine out
  function automatic void tilt_sincos(input longint ang, output longint s,
                                      output longint c);
    longint x, y, z, dx, dy;
    bit     flip;
    x = InvGain;
    y = 0;
    flip = 0;
    // fold into +-180, then into +-90 with a sign flip
    while (ang > Q16Deg180) ang -= Q16Deg360;
    while (ang < -Q16Deg180) ang += Q16Deg360;
    if (ang > Q16Deg90) begin
      ang -= Q16Deg180;
      flip = 1;
    end else if (ang < -Q16Deg90) begin
      ang += Q16Deg180;
      flip = 1;
    end
    z = ang;
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= AtanTab[i];
      end else begin
        x += dx;
        y -= dy;
        z += AtanTab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // vectoring cordic: atan2 of the horizontal components in q16 degrees
  function automatic longint heading_atan2(input longint yv, input longint xv);
    longint z, dx, dy;
    z = 0;
    if (xv < 0) begin
      // left half plane: start from +-180 and mirror the vector
      z = (yv >= 0) ? Q16Deg180 : -Q16Deg180;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv += dx;
        yv -= dy;
        z += AtanTab[i];
      end else begin
        xv -= dx;
        yv += dy;
        z -= AtanTab[i];
      end
    end
    return z;
  endfunction

  // full predictor: tilt compensation, heading, rounding and clamp
  function automatic logic signed [15:0] predict_heading(input sample_t smp);
    longint sp, cp, sr, cr, spsr, spcr, yh, xh, h;
    tilt_sincos(longint'(smp.pitch) <<< (16 - FracBits), sp, cp);
    tilt_sincos(longint'(smp.roll) <<< (16 - FracBits), sr, cr);
    spsr = (sp * sr) >>> 30;
    spcr = (sp * cr) >>> 30;
    yh = longint'(smp.mz) * sr - longint'(smp.my) * cr;
    xh = longint'(smp.mx) * cp + longint'(smp.my) * spsr + longint'(smp.mz) * spcr;
    if (xh == 0 && yh == 0) begin
      h = 0;
    end else begin
      // round half up from q16 down to the output fraction
      h = (heading_atan2(yh, xh) + (64'sd1 <<< (15 - FracBits))) >>> (16 - FracBits);
    end
    if (h > AngMax) h = AngMax;
    if (h < -AngMax) h = -AngMax;
    return h[15:0];
  endfunction

  function automatic sample_t make_sample(input int x, input int y, input int z,
                                          input int p, input int r);
    sample_t smp;
    smp.mx = x[15:0];
    smp.my = y[15:0];
    smp.mz = z[15:0];
    smp.pitch = p[15:0];
    smp.roll = r[15:0];
    return smp;
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2 * AngMax) - AngMax;
      1: return AngMax - $urandom_range(0, 3);           // close to +180
      2: return $urandom_range(0, 3) - AngMax;
      3: return (90 << FracBits) + $urandom_range(0, 6) - 3;   // around the fold at 90
      4: return $urandom_range(0, 2560) - 1280;           // mild tilt
      default: return $urandom_range(0, 2 * AngMax) - AngMax;
    endcase
  endfunction

  function automatic int rand_axis();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 64) - 32;               // tiny vectors
      2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // stimulus: directed corners first, then random samples
  initial begin
    int a90;
    a90 = 90 << FracBits;
    // zero vector gives heading 0
    sample_q.push_back(make_sample(0, 0, 0, 0, 0));
    sample_q.push_back(make_sample(0, 0, 0, AngMax, -AngMax));
    // level sensor, positive x and both y directions
    sample_q.push_back(make_sample(1000, 0, 0, 0, 0));
    sample_q.push_back(make_sample(0, -1000, 0, 0, 0));
    sample_q.push_back(make_sample(0, 1000, 0, 0, 0));
    // negative x with zero, positive and negative y: start from +180 or -180
    sample_q.push_back(make_sample(-100, 0, 0, 0, 0));
    sample_q.push_back(make_sample(-100, 1, 0, 0, 0));
    sample_q.push_back(make_sample(-100, -1, 0, 0, 0));
    // axis extremes
    sample_q.push_back(make_sample(32767, 32767, 32767, 0, 0));
    sample_q.push_back(make_sample(-32768, -32768, -32768, 0, 0));
    sample_q.push_back(make_sample(-32768, 32767, -32768, AngMax, AngMax));
    sample_q.push_back(make_sample(32767, -32768, 32767, -AngMax, -AngMax));
    // angle extremes and the fold at +-90
    sample_q.push_back(make_sample(1200, -700, 300, AngMax, 0));
    sample_q.push_back(make_sample(1200, -700, 300, -AngMax, 0));
    sample_q.push_back(make_sample(1200, -700, 300, 0, AngMax));
    sample_q.push_back(make_sample(1200, -700, 300, 0, -AngMax));
    sample_q.push_back(make_sample(1200, -700, 300, a90, a90));
    sample_q.push_back(make_sample(1200, -700, 300, a90 + 1, -a90 - 1));
    sample_q.push_back(make_sample(1200, -700, 300, -a90, a90 + 1));
    sample_q.push_back(make_sample(-5000, 4000, -3000, a90 - 1, -a90));
    // clamp region near +-180 output
    sample_q.push_back(make_sample(-30000, 1, 0, 0, 0));
    sample_q.push_back(make_sample(-30000, -1, 0, 0, 0));
    for (int i = 0; i < NumRandom; i++) begin
      sample_q.push_back(make_sample(rand_axis(), rand_axis(), rand_axis(),
                                     rand_angle(), rand_angle()));
    end
  end

  // reset, then wait for the queue to drain and the pipe to empty
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (sample_q.size() == 0 && !in_valid);
    wait (heading_q.size() == 0);
    repeat (Latency + 20) @(posedge clk);
    $display("covered %0d samples incl. zero vector, quadrant, fold and clamp corners",
             n_sent);
    $display("%0d headings checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout with %0d headings outstanding", heading_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // monitor: record input transfers and check output transfers at the rising edge
  always @(posedge clk) begin
    logic signed [15:0] want;
    sample_t            smp;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        smp.mx = mag_x;
        smp.my = mag_y;
        smp.mz = mag_z;
        smp.pitch = pitch_deg;
        smp.roll = roll_deg;
        heading_q.push_back(predict_heading(smp));
        n_sent++;
        in_took = 1;
      end
      if (out_valid && !out_stall) begin
        out_took = 1;
        if (heading_q.size() == 0) begin
          $error("heading_deg: unexpected transfer, value %0d", heading_deg);
          n_errors++;
        end else begin
          want = heading_q.pop_front();
          n_checked++;
          if (heading_deg !== want) begin
            $error("heading_deg: expected %0d, actual %0d", want, heading_deg);
            n_errors++;
          end
        end
      end
    end
  end

  // driver: new sample after the previous transfer and its drawn gap
  always @(negedge clk) begin
    sample_t smp;
    if (!rst && (!in_valid || in_took)) begin
      in_took = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        smp = sample_q.pop_front();
        mag_x <= smp.mx;
        mag_y <= smp.my;
        mag_z <= smp.mz;
        pitch_deg <= smp.pitch;
        roll_deg <= smp.roll;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        send_gap = no_gaps ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall for a drawn number of cycles after each output transfer
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) begin
        out_took = 0;
        if ($urandom_range(0, 39) == 0) no_stalls = !no_stalls;
        stall_left = no_stalls ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end
endmodule

// ===== sim.f =====
rtl/core/tch_pkg.sv
rtl/core/tch_rot_cell.sv
rtl/core/tch_vec_cell.sv
rtl/core/tilt_compensated_heading.sv
tb/tb_top.sv
